// ===== sv/jdd_pkg.sv =====
`default_nettype none

package jdd_pkg;

    // frame and channel geometry
    localparam int NUM_CH           = 4;
    localparam int SAMPLE_W         = 24;
    localparam int SUM_W            = 27;
    localparam int COUNT_W          = 3;
    localparam int LEVEL_W          = 9;
    localparam int NUM_EN           = 3;

    localparam logic [COUNT_W-1:0] FRAMES_PER_BLOCK = 3'd5;

    // enable flag positions in the input tuser
    localparam int EN_CLIP          = 0;
    localparam int EN_LEFT          = 1;
    localparam int EN_RIGHT         = 2;

    // sum -> level scaling: v = floor(sum * 100 / 2^24)
    localparam logic [6:0]  SCALE   = 7'd100;
    localparam int          SCALE_SHIFT = 24;
    localparam int          PROD_W  = SUM_W + 7;
    localparam int          VRAW_W  = PROD_W - SCALE_SHIFT;

    localparam logic [LEVEL_W-1:0] V_MIN   = 9'd50;
    localparam logic [LEVEL_W-1:0] V_MAX   = 9'd450;
    localparam logic [LEVEL_W-1:0] DEAD_LO = 9'd240;
    localparam logic [LEVEL_W-1:0] DEAD_HI = 9'd260;
    localparam logic [LEVEL_W-1:0] CENTER  = 9'd250;

    localparam logic [7:0]  BYTE_MID    = 8'd128;
    localparam logic [7:0]  BYTE_TOP    = 8'd127;

    // floor(x / 25) = (x * 1311) >> 15, exact for x <= 3224
    localparam logic [10:0] RECIP_25    = 11'd1311;
    localparam int          RECIP_SHIFT = 15;
    localparam logic [11:0] CEIL_BIAS   = 12'd24;

    // per-frame result handed from the accumulator to the mapper; done marks the block end
    typedef struct packed {
        logic                                done;
        logic [NUM_CH-1:0]                   en;
        logic [NUM_CH-1:0][LEVEL_W-1:0]      level;
    } blk_t;

endpackage

`default_nettype wire

// ===== sv/jdd_accum.sv =====
`default_nettype none

module jdd_accum (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            in_valid,
    output logic                                                 in_ready,
    input  wire logic [jdd_pkg::NUM_CH-1:0][jdd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [jdd_pkg::NUM_EN-1:0]                      enables,
    output logic                                                 blk_valid,
    input  wire logic                                            blk_ready,
    output jdd_pkg::blk_t                                        blk
);

    logic [jdd_pkg::NUM_CH-1:0][jdd_pkg::SUM_W-1:0]   sum_reg;
    logic [jdd_pkg::NUM_CH-1:0][jdd_pkg::SUM_W-1:0]   sum_next;
    logic [jdd_pkg::NUM_CH-1:0][jdd_pkg::LEVEL_W-1:0] level_next;
    logic [jdd_pkg::COUNT_W-1:0]                      count_reg;
    logic [jdd_pkg::COUNT_W-1:0]                      count_inc;
    logic                                             done_next;
    logic                                             valid_reg;
    jdd_pkg::blk_t                                    blk_reg;
    logic                                             fire;

    assign in_ready = !valid_reg || blk_ready;
    assign fire     = in_valid && in_ready;

    assign count_inc = count_reg + 1'b1;
    assign done_next = (count_inc == jdd_pkg::FRAMES_PER_BLOCK);

    always_comb
    begin
        logic [jdd_pkg::PROD_W-1:0] prod;
        logic [jdd_pkg::VRAW_W-1:0] vraw;
        for (int i = 0; i < jdd_pkg::NUM_CH; i++)
        begin
            sum_next[i] = sum_reg[i] + jdd_pkg::SUM_W'(sample[i]);
            prod = jdd_pkg::PROD_W'(sum_next[i]) * jdd_pkg::PROD_W'(jdd_pkg::SCALE);
            vraw = prod[jdd_pkg::PROD_W-1:jdd_pkg::SCALE_SHIFT];
            if (vraw > jdd_pkg::VRAW_W'(jdd_pkg::V_MAX))
                level_next[i] = jdd_pkg::V_MAX;
            else if (vraw < jdd_pkg::VRAW_W'(jdd_pkg::V_MIN))
                level_next[i] = jdd_pkg::V_MIN;
            else
                level_next[i] = vraw[jdd_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (done_next)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_inc;
                end
                valid_reg <= 1'b1;
            end
            else if (blk_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            blk_reg.done  <= done_next;
            blk_reg.en    <= {enables[jdd_pkg::EN_RIGHT], enables[jdd_pkg::EN_LEFT],
                              enables[jdd_pkg::EN_CLIP], enables[jdd_pkg::EN_CLIP]};
            blk_reg.level <= level_next;
        end
    end

    assign blk_valid = valid_reg;
    assign blk       = blk_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < jdd_pkg::FRAMES_PER_BLOCK)
        else $error("frame count reached block length");

    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && done_next) |=> (sum_reg == '0))
        else $error("sums not cleared at block end");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (blk_reg.level[0] >= jdd_pkg::V_MIN && blk_reg.level[0] <= jdd_pkg::V_MAX))
        else $error("level out of clamp range");
`endif

endmodule

`default_nettype wire

// ===== sv/jdd_map.sv =====
`default_nettype none

module jdd_map (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          blk_valid,
    output logic               blk_ready,
    input  wire jdd_pkg::blk_t blk,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_word,
    output logic               out_done
);

    function automatic logic [7:0] map_level(input logic [jdd_pkg::LEVEL_W-1:0] v);
        logic [7:0]  d;
        logic [11:0] x;
        logic [22:0] q;
        begin
            if (v > jdd_pkg::DEAD_LO && v < jdd_pkg::DEAD_HI)
                return jdd_pkg::BYTE_MID;
            else if (v > jdd_pkg::CENTER)
            begin
                // 127 + floor(16*(v-250)/25)
                d = 8'(v - jdd_pkg::CENTER);
                x = {d, 4'b0000};
                q = 23'(x) * 23'(jdd_pkg::RECIP_25);
                return jdd_pkg::BYTE_TOP + q[22:jdd_pkg::RECIP_SHIFT];
            end
            else
            begin
                // 128 - ceil(16*(250-v)/25)
                d = 8'(jdd_pkg::CENTER - v);
                x = {d, 4'b0000} + jdd_pkg::CEIL_BIAS;
                q = 23'(x) * 23'(jdd_pkg::RECIP_25);
                return jdd_pkg::BYTE_MID - q[22:jdd_pkg::RECIP_SHIFT];
            end
        end
    endfunction

    logic [jdd_pkg::NUM_CH-1:0][7:0] held_reg;
    logic [jdd_pkg::NUM_CH-1:0][7:0] held_next;
    logic                            valid_reg;
    logic [31:0]                     word_reg;
    logic                            done_reg;
    logic                            fire;

    assign blk_ready = !valid_reg || out_ready;
    assign fire      = blk_valid && blk_ready;

    always_comb
    begin
        for (int i = 0; i < jdd_pkg::NUM_CH; i++)
        begin
            if (!blk.done)
                held_next[i] = held_reg[i];
            else if (blk.en[i])
                held_next[i] = map_level(blk.level[i]);
            else
                held_next[i] = jdd_pkg::BYTE_MID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= {jdd_pkg::NUM_CH{jdd_pkg::BYTE_MID}};
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                held_reg  <= held_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            word_reg <= held_next;
            done_reg <= blk.done;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_done  = done_reg;

`ifndef SYNTHESIS
    a_disabled_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && blk.done && !blk.en[0]) |=> (held_reg[0] == jdd_pkg::BYTE_MID))
        else $error("disabled channel not centered");

    a_hold_between: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !blk.done) |=> $stable(held_reg))
        else $error("held bytes changed outside block end");
`endif

endmodule

`default_nettype wire

// ===== sv/joystick_decimate_deadzone_map.sv =====
`default_nettype none

// channel  | dir | tdata (low bit up)                         | tuser (low bit up)
// ---------+-----+--------------------------------------------+---------------------------------
// s_*      | in  | sample_ch0, sample_ch1, sample_ch2,        | clip_enable, left_enable,
//          |     | sample_ch3 (24 b each)                     | right_enable
// m_*      | out | stick_word (32 b)                          | block_done
//
// One word in, one word out; a new word can be taken every cycle while m_tready is high.
// Pipeline registers in order: input register, accumulate/scale register, map/output register.
// Each stage's ready is !valid || next ready, so a full pipe stalls only on m_tready low.
// rst_n (async, active low) clears sums and frame count and sets held bytes to 128.
// Scale multiply (27 x 7) and map multiply (12 x 11) sit in separate stages.

module joystick_decimate_deadzone_map (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  wire logic [2:0]   s_tuser,   // clip_enable, left_enable, right_enable
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // stick_word
    output logic [0:0]        m_tuser    // block_done
);

    // input register
    logic                                                   in_valid_reg;
    logic [jdd_pkg::NUM_CH-1:0][jdd_pkg::SAMPLE_W-1:0]      in_sample_reg;
    logic [jdd_pkg::NUM_EN-1:0]                             in_en_reg;
    logic                                                   acc_ready;

    // accumulate -> map
    logic          blk_valid;
    logic          blk_ready;
    jdd_pkg::blk_t blk;

    logic          out_done;

    assign s_tready = !in_valid_reg || acc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= s_tdata;
            in_en_reg     <= s_tuser;
        end
    end

    jdd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (acc_ready),
        .sample    (in_sample_reg),
        .enables   (in_en_reg),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk)
    );

    jdd_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_done  (out_done)
    );

    assign m_tuser = out_done;

endmodule

`default_nettype wire
